// ----- rtl/core/mra_pkg.sv -----
// Shared types and constants for the mouse report accumulator.
// Holds operation and report codes, the tick record type and queue sizing.
// No dependencies.
`default_nettype none

package mra_pkg;

    localparam int OP_W   = 2;
    localparam int KIND_W = 2;
    localparam int BTN_W  = 3;
    localparam int DATA_W = 8;

    localparam logic [OP_W-1:0] OP_BUTTON = 2'd0;
    localparam logic [OP_W-1:0] OP_MOTION = 2'd1;
    localparam logic [OP_W-1:0] OP_WHEEL  = 2'd2;
    localparam logic [OP_W-1:0] OP_SEND   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SCROLL  = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 2);

    localparam logic signed [DATA_W-1:0] CLAMP_MIN = -8'sd128;
    localparam logic signed [DATA_W-1:0] CLAMP_MAX = 8'sd127;

    typedef struct packed {
        logic                     has_btn;
        logic                     pressed;
        logic [BTN_W-1:0]         button;
        logic signed [DATA_W-1:0] dx;
        logic signed [DATA_W-1:0] dy;
        logic signed [DATA_W-1:0] wh;
    } tick_t;

endpackage

`default_nettype wire

// ----- rtl/core/mouse_report_accumulator.sv -----
// Mouse report accumulator: top level joining front end, tick queue and back end.
// Depends on mra_pkg, mra_front, mra_queue and mra_back.
//
// Input channel: drive an item on operation and its fields with push high; the
// item is taken on a clock edge where full is low. Wheel items, and button and motion
// items while link_up is high, take effect on that edge; one item per cycle is sustained while full stays low.
// A send tick taken with link_up high that has something to report becomes a record
// that passes the front register, tick queue and back-end work register, then yields
// one to three reports, one per cycle while pop stays high, the final one marked by last_report.
// Result channel: a report is valid while empty is low and leaves on a clock
// edge where pop is high. While pop stays low the result register holds and the
// four-entry tick queue fills; full rises once it cannot take another tick.
// Output rate is one report per cycle while pop stays high, set by the single result register.
// The user writes link_up through cfg_write/cfg_data only while the block is idle; the block does not enforce this.
// Reset clears link_up, accumulators, wheel, ring pointers and all queues;
// the button ring contents are not cleared and need no clearing pass.
`default_nettype none

module mouse_report_accumulator #(
    parameter int RING_DEPTH = 32,
    parameter int ACC_WIDTH  = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire                                  cfg_data,
    input  wire                                  push,
    output logic                                 full,
    input  wire  [mra_pkg::OP_W-1:0]             operation,
    input  wire  [mra_pkg::BTN_W-1:0]            button_code,
    input  wire                                  pressed,
    input  wire  signed [mra_pkg::DATA_W-1:0]    delta_x,
    input  wire  signed [mra_pkg::DATA_W-1:0]    delta_y,
    input  wire  signed [mra_pkg::DATA_W-1:0]    wheel_amount,
    output logic                                 empty,
    input  wire                                  pop,
    output logic [mra_pkg::KIND_W-1:0]           report_kind,
    output logic [mra_pkg::BTN_W-1:0]            report_button,
    output logic signed [mra_pkg::DATA_W-1:0]    move_x,
    output logic signed [mra_pkg::DATA_W-1:0]    move_y,
    output logic signed [mra_pkg::DATA_W-1:0]    scroll,
    output logic                                 last_report
);

    logic                            q_push;
    mra_pkg::tick_t                  q_wr_data;
    logic                            q_pop;
    logic                            q_valid;
    mra_pkg::tick_t                  q_rd_data;
    logic [mra_pkg::QCNT_W-1:0]      q_count;

    mra_front #(
        .RING_DEPTH (RING_DEPTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .button_code  (button_code),
        .pressed      (pressed),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .wheel_amount (wheel_amount),
        .q_count      (q_count),
        .q_push       (q_push),
        .q_data       (q_wr_data)
    );

    mra_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wr_data),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data),
        .count    (q_count)
    );

    mra_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_rd_data),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .report_kind   (report_kind),
        .report_button (report_button),
        .move_x        (move_x),
        .move_y        (move_y),
        .scroll        (scroll),
        .last_report   (last_report)
    );

endmodule

`default_nettype wire

// ----- rtl/core/mra_front.sv -----
// Front end: accepts items, updates accumulators, wheel and button ring.
// Emits one tick record per reportable send tick. Depends on mra_pkg.
`default_nettype none

module mra_front #(
    parameter int RING_DEPTH = 32,
    parameter int ACC_WIDTH  = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire                                  cfg_data,
    input  wire                                  push,
    output logic                                 full,
    input  wire  [mra_pkg::OP_W-1:0]             operation,
    input  wire  [mra_pkg::BTN_W-1:0]            button_code,
    input  wire                                  pressed,
    input  wire  signed [mra_pkg::DATA_W-1:0]    delta_x,
    input  wire  signed [mra_pkg::DATA_W-1:0]    delta_y,
    input  wire  signed [mra_pkg::DATA_W-1:0]    wheel_amount,
    input  wire  [mra_pkg::QCNT_W-1:0]           q_count,
    output logic                                 q_push,
    output mra_pkg::tick_t                       q_data
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam int ENT_W = mra_pkg::BTN_W + 1;
    localparam int DW    = mra_pkg::DATA_W;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic [ENT_W-1:0] ring_mem [RING_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    logic                          link_up_reg;
    logic signed [ACC_WIDTH-1:0]   x_acc_reg, x_acc_next;
    logic signed [ACC_WIDTH-1:0]   y_acc_reg, y_acc_next;
    logic signed [DW-1:0]          wheel_reg, wheel_next;
    logic [PTR_W-1:0]              head_reg, head_next;
    logic [PTR_W-1:0]              tail_reg, tail_next;

    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_has_btn_reg;
    logic signed [DW-1:0]          s1_dx_reg, s1_dy_reg, s1_wh_reg;

    logic                          accept;
    logic                          wr_en;
    logic                          rd_en;
    logic                          has_btn;
    logic                          send;
    logic signed [DW-1:0]          cx, cy;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic signed [DW-1:0]        d
    );
        logic signed [ACC_WIDTH:0] sum;
        sum = {acc[ACC_WIDTH-1], acc} + {{(ACC_WIDTH-DW+1){d[DW-1]}}, d};
        if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1])
            sat_add = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        else
            sat_add = sum[ACC_WIDTH-1:0];
    endfunction

    function automatic logic signed [DW-1:0] clamp8(input logic signed [ACC_WIDTH-1:0] acc);
        logic [ACC_WIDTH-DW:0] upper;
        upper = acc[ACC_WIDTH-1:DW-1];
        if ((&upper) || !(|upper))
            clamp8 = acc[DW-1:0];
        else
            clamp8 = acc[ACC_WIDTH-1] ? mra_pkg::CLAMP_MIN : mra_pkg::CLAMP_MAX;
    endfunction

    assign full   = ({1'b0, q_count} + (mra_pkg::QCNT_W+1)'(s1_valid_reg))
                    >= (mra_pkg::QCNT_W+1)'(mra_pkg::QUEUE_DEPTH);
    assign accept = push && !full;
    assign has_btn = head_reg != tail_reg;
    assign cx = clamp8(x_acc_reg);
    assign cy = clamp8(y_acc_reg);
    assign send = accept && (operation == mra_pkg::OP_SEND);

    always_comb
    begin
        x_acc_next    = x_acc_reg;
        y_acc_next    = y_acc_reg;
        wheel_next    = wheel_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        s1_valid_next = 1'b0;
        if (accept)
        begin
            case (operation)
                mra_pkg::OP_BUTTON:
                begin
                    if (link_up_reg)
                    begin
                        wr_en     = 1'b1;
                        tail_next = ptr_inc(tail_reg);
                    end
                end
                mra_pkg::OP_MOTION:
                begin
                    if (link_up_reg)
                    begin
                        x_acc_next = sat_add(x_acc_reg, delta_x);
                        y_acc_next = sat_add(y_acc_reg, delta_y);
                    end
                end
                mra_pkg::OP_WHEEL:
                begin
                    wheel_next = wheel_amount;
                end
                mra_pkg::OP_SEND:
                begin
                    if (has_btn)
                    begin
                        rd_en     = 1'b1;
                        head_next = ptr_inc(head_reg);
                    end
                    x_acc_next    = x_acc_reg - {{(ACC_WIDTH-DW){cx[DW-1]}}, cx};
                    y_acc_next    = y_acc_reg - {{(ACC_WIDTH-DW){cy[DW-1]}}, cy};
                    wheel_next    = '0;
                    s1_valid_next = link_up_reg && (has_btn || (cx != '0) || (cy != '0)
                                                    || (wheel_reg != '0));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_up_reg  <= 1'b0;
            x_acc_reg    <= '0;
            y_acc_reg    <= '0;
            wheel_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                link_up_reg <= cfg_data;
            x_acc_reg    <= x_acc_next;
            y_acc_reg    <= y_acc_next;
            wheel_reg    <= wheel_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // capture the tick payload on a send, in step with the ring read
    always_ff @(posedge clk)
    begin
        if (send)
        begin
            s1_has_btn_reg <= has_btn;
            s1_dx_reg      <= cx;
            s1_dy_reg      <= cy;
            s1_wh_reg      <= wheel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[tail_reg] <= {pressed, button_code};
        if (rd_en)
            rd_data_reg <= ring_mem[head_reg];
    end

    always_comb
    begin
        q_push         = s1_valid_reg;
        q_data.has_btn = s1_has_btn_reg;
        q_data.pressed = rd_data_reg[ENT_W-1];
        q_data.button  = rd_data_reg[mra_pkg::BTN_W-1:0];
        q_data.dx      = s1_dx_reg;
        q_data.dy      = s1_dy_reg;
        q_data.wh      = s1_wh_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/core/mra_queue.sv -----
// Short queue of tick records between the front and back ends.
// Depends on mra_pkg for the record type and depth.
`default_nettype none

module mra_queue (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          wr_en,
    input  mra_pkg::tick_t               wr_data,
    input  wire                          rd_en,
    output logic                         rd_valid,
    output mra_pkg::tick_t               rd_data,
    output logic [mra_pkg::QCNT_W-1:0]   count
);

    mra_pkg::tick_t                  entries_reg [mra_pkg::QUEUE_DEPTH];
    logic [mra_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [mra_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                            do_rd;

    assign rd_valid = count_reg != '0;
    assign rd_data  = entries_reg[rd_ptr_reg];
    assign count    = count_reg;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg + mra_pkg::QCNT_W'(wr_en) - mra_pkg::QCNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + mra_pkg::QPTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + mra_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ----- rtl/core/mra_back.sv -----
// Back end: expands tick records into button, move and scroll reports.
// Drives the result register. Depends on mra_pkg.
`default_nettype none

module mra_back (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  q_valid,
    input  mra_pkg::tick_t                       q_data,
    output logic                                 q_pop,
    output logic                                 empty,
    input  wire                                  pop,
    output logic [mra_pkg::KIND_W-1:0]           report_kind,
    output logic [mra_pkg::BTN_W-1:0]            report_button,
    output logic signed [mra_pkg::DATA_W-1:0]    move_x,
    output logic signed [mra_pkg::DATA_W-1:0]    move_y,
    output logic signed [mra_pkg::DATA_W-1:0]    scroll,
    output logic                                 last_report
);

    localparam int DW = mra_pkg::DATA_W;

    mra_pkg::tick_t                 work_reg, work_next;
    logic [2:0]                     pend_reg, pend_next;
    logic                           out_valid_reg, out_valid_next;
    logic [mra_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [mra_pkg::BTN_W-1:0]      button_reg, button_next;
    logic signed [DW-1:0]           mx_reg, mx_next;
    logic signed [DW-1:0]           my_reg, my_next;
    logic signed [DW-1:0]           sc_reg, sc_next;
    logic                           last_reg, last_next;

    logic                           out_ready;
    logic                           emit;
    logic [2:0]                     pend_after;
    logic [2:0]                     pend_cur;

    assign out_ready = !out_valid_reg || pop;
    assign emit      = out_ready && (pend_reg != 3'b000);

    always_comb
    begin
        kind_next   = kind_reg;
        button_next = button_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        sc_next     = sc_reg;
        pend_after  = pend_reg;
        if (pend_reg[0])
        begin
            kind_next   = work_reg.pressed ? mra_pkg::KIND_PRESS : mra_pkg::KIND_RELEASE;
            button_next = work_reg.button;
            mx_next     = '0;
            my_next     = '0;
            sc_next     = '0;
            pend_after  = pend_reg & 3'b110;
        end
        else if (pend_reg[1])
        begin
            kind_next   = mra_pkg::KIND_MOVE;
            button_next = '0;
            mx_next     = work_reg.dx;
            my_next     = work_reg.dy;
            sc_next     = '0;
            pend_after  = pend_reg & 3'b101;
        end
        else
        begin
            kind_next   = mra_pkg::KIND_SCROLL;
            button_next = '0;
            mx_next     = '0;
            my_next     = '0;
            sc_next     = work_reg.wh;
            pend_after  = 3'b000;
        end
        last_next = pend_after == 3'b000;

        pend_cur  = emit ? pend_after : pend_reg;
        q_pop     = q_valid && (pend_cur == 3'b000);
        work_next = work_reg;
        pend_next = pend_cur;
        if (q_pop)
        begin
            work_next = q_data;
            pend_next = {q_data.wh != '0, (q_data.dx != '0) || (q_data.dy != '0),
                         q_data.has_btn};
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (emit)
        begin
            kind_reg   <= kind_next;
            button_reg <= button_next;
            mx_reg     <= mx_next;
            my_reg     <= my_next;
            sc_reg     <= sc_next;
            last_reg   <= last_next;
        end
    end

    assign empty         = !out_valid_reg;
    assign report_kind   = kind_reg;
    assign report_button = button_reg;
    assign move_x        = mx_reg;
    assign move_y        = my_reg;
    assign scroll        = sc_reg;
    assign last_report   = last_reg;

endmodule

`default_nettype wire
